// ----- rtl/dsc_pkg.sv -----
`default_nettype none
package dsc_pkg;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned InUserW  = 1;
  localparam int unsigned OutDataW = 24;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned AngleW   = 10;

  localparam logic [7:0]  AngleMax = 8'd180;

  localparam logic [7:0]  RstOpenA    = 8'd0;
  localparam logic [7:0]  RstClosedA  = 8'd90;
  localparam logic [7:0]  RstOpenB    = 8'd180;
  localparam logic [7:0]  RstClosedB  = 8'd90;
  localparam logic [9:0]  RstLightThr = 10'd512;
  localparam logic [15:0] RstDelay    = 16'd5000;
  localparam logic        RstToggle   = 1'b0;

  typedef enum logic [1:0] {
    MODE_OPENED  = 2'd0,
    MODE_CLOSING = 2'd1,
    MODE_CLOSED  = 2'd2,
    MODE_OPENING = 2'd3
  } mode_e;

  typedef enum logic {
    REQ_UPDATE = 1'b0,
    REQ_HOME   = 1'b1
  } req_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_OPEN_A    = 3'd0,
    CFG_CLOSED_A  = 3'd1,
    CFG_OPEN_B    = 3'd2,
    CFG_CLOSED_B  = 3'd3,
    CFG_LIGHT_THR = 3'd4,
    CFG_DELAY     = 3'd5,
    CFG_TOGGLE    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]  open_a;
    logic [7:0]  closed_a;
    logic [7:0]  open_b;
    logic [7:0]  closed_b;
    logic [9:0]  light_thr;
    logic [15:0] delay_ms;
    logic        toggle;
  } cfg_t;

  typedef struct packed {
    mode_e             mode;
    logic [AngleW-1:0] angle_a;
    logic [AngleW-1:0] angle_b;
    logic [31:0]       opened_at;
  } state_t;

  // Packed so that the last field sits in the lowest bits.
  typedef struct packed {
    logic [31:0] now_ms;
    logic [9:0]  light_sample;
    logic        button;
  } in_data_t;

  typedef struct packed {
    req_e     req_type;
    in_data_t data;
  } in_item_t;

  typedef struct packed {
    logic       light_above;
    logic [7:0] servo_b_angle;
    logic [7:0] servo_a_angle;
    mode_e      door_mode;
  } out_item_t;

endpackage
`default_nettype wire

// ----- rtl/dsc_cfg.sv -----
`default_nettype none
module dsc_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [dsc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dsc_pkg::CfgDataW-1:0] cfg_wdata_i,
  output dsc_pkg::cfg_t                cfg_o
);
  import dsc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OPEN_A:    cfg_d.open_a    = cfg_wdata_i[7:0];
        CFG_CLOSED_A:  cfg_d.closed_a  = cfg_wdata_i[7:0];
        CFG_OPEN_B:    cfg_d.open_b    = cfg_wdata_i[7:0];
        CFG_CLOSED_B:  cfg_d.closed_b  = cfg_wdata_i[7:0];
        CFG_LIGHT_THR: cfg_d.light_thr = cfg_wdata_i[9:0];
        CFG_DELAY:     cfg_d.delay_ms  = cfg_wdata_i[15:0];
        CFG_TOGGLE:    cfg_d.toggle    = cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.open_a    <= RstOpenA;
      cfg_q.closed_a  <= RstClosedA;
      cfg_q.open_b    <= RstOpenB;
      cfg_q.closed_b  <= RstClosedB;
      cfg_q.light_thr <= RstLightThr;
      cfg_q.delay_ms  <= RstDelay;
      cfg_q.toggle    <= RstToggle;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ----- rtl/dsc_step.sv -----
`default_nettype none
module dsc_step (
  input  dsc_pkg::cfg_t     cfg_i,
  input  dsc_pkg::state_t   state_i,
  input  dsc_pkg::in_item_t item_i,
  output dsc_pkg::state_t   state_o,
  output dsc_pkg::out_item_t result_o
);
  import dsc_pkg::*;

  function automatic logic [7:0] clamp_angle(input logic [AngleW-1:0] ang);
    logic [7:0] res;
    if (ang[AngleW-1]) begin
      res = 8'd0;
    end else if (ang > {{(AngleW-8){1'b0}}, AngleMax}) begin
      res = AngleMax;
    end else begin
      res = ang[7:0];
    end
    return res;
  endfunction

  function automatic logic [AngleW-1:0] home_angle(input logic [7:0] open_v);
    return {{(AngleW-8){1'b0}}, (open_v > AngleMax) ? AngleMax : open_v};
  endfunction

  function automatic logic [AngleW-1:0] step_angle(input logic [AngleW-1:0] ang,
                                                  input logic [7:0] open_v,
                                                  input logic [7:0] closed_v,
                                                  input logic closing);
    logic up;
    up = (open_v < closed_v) ? closing : !closing;
    return up ? ang + AngleW'(1) : ang - AngleW'(1);
  endfunction

  logic        above;
  logic [31:0] elapsed;
  logic        closing;
  state_t      nxt;

  assign above   = item_i.data.light_sample > cfg_i.light_thr;
  assign elapsed = item_i.data.now_ms - state_i.opened_at;

  always_comb begin
    nxt     = state_i;
    closing = 1'b0;
    if (item_i.req_type == REQ_HOME) begin
      nxt.mode    = MODE_OPENED;
      nxt.angle_a = home_angle(cfg_i.open_a);
      nxt.angle_b = home_angle(cfg_i.open_b);
    end else begin
      if (cfg_i.toggle) begin
        if (state_i.mode == MODE_CLOSED && item_i.data.button) begin
          nxt.mode = MODE_OPENING;
        end else if (state_i.mode == MODE_OPENED && item_i.data.button) begin
          nxt.mode = MODE_CLOSING;
        end
      end else begin
        if (state_i.mode == MODE_CLOSED && item_i.data.button) begin
          nxt.mode      = MODE_OPENING;
          nxt.opened_at = item_i.data.now_ms;
        end else if (state_i.mode == MODE_OPENED && above &&
                     (elapsed >= {16'd0, cfg_i.delay_ms} || item_i.data.button)) begin
          nxt.mode = MODE_CLOSING;
        end
      end

      if (nxt.mode == MODE_CLOSING || nxt.mode == MODE_OPENING) begin
        closing     = (nxt.mode == MODE_CLOSING);
        nxt.angle_a = step_angle(state_i.angle_a, cfg_i.open_a, cfg_i.closed_a, closing);
        nxt.angle_b = step_angle(state_i.angle_b, cfg_i.open_b, cfg_i.closed_b, closing);
      end

      if (nxt.angle_a == {{(AngleW-8){1'b0}}, cfg_i.open_a}) begin
        nxt.mode = MODE_OPENED;
      end else if (nxt.angle_a == {{(AngleW-8){1'b0}}, cfg_i.closed_a}) begin
        nxt.mode = MODE_CLOSED;
      end
    end
  end

  assign state_o                = nxt;
  assign result_o.door_mode     = nxt.mode;
  assign result_o.servo_a_angle = clamp_angle(nxt.angle_a);
  assign result_o.servo_b_angle = clamp_angle(nxt.angle_b);
  assign result_o.light_above   = above;

endmodule
`default_nettype wire

// ----- rtl/twin_servo_door_controller.sv -----
// Channel  | Direction | Contents
// s_axis   | in        | tuser: req_type; tdata: button, light_sample, now_ms
// m_axis   | out       | tdata: door_mode, servo_a_angle, servo_b_angle, light_above
// cfg      | in        | register index and write data, one write per cycle
//
// One item is accepted every cycle unless the output stalls.
// The input register feeds the step logic, which updates the door state and the
// result register in the same cycle, so each item sees the state left by the last.
// A stalled output holds the result register and then the input register; the
// input side stalls only when both are full. Reset empties both and restores state.
`default_nettype none
module twin_servo_door_controller (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // button [0], light_sample [10:1], now_ms [42:11], zero fill above
  input  logic [dsc_pkg::InDataW-1:0]  s_axis_tdata_i,
  // req_type [0]
  input  logic [dsc_pkg::InUserW-1:0]  s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // door_mode [1:0], servo_a_angle [9:2], servo_b_angle [17:10], light_above [18]
  output logic [dsc_pkg::OutDataW-1:0] m_axis_tdata_o,
  input  logic                         cfg_we_i,
  input  logic [dsc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dsc_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import dsc_pkg::*;

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t out_q;
  logic      out_valid_q;
  state_t    state_q, state_d;
  out_item_t result;
  logic      out_free;
  logic      advance;
  logic      in_take;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || out_free;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  dsc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  dsc_step u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .item_i   (in_q),
    .state_o  (state_d),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q.mode      <= MODE_OPENED;
      state_q.angle_a   <= {{(AngleW-8){1'b0}}, RstOpenA};
      state_q.angle_b   <= {{(AngleW-8){1'b0}}, RstOpenB};
      state_q.opened_at <= 32'd0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.req_type <= req_e'(s_axis_tuser_i[0]);
      in_q.data     <= s_axis_tdata_i[$bits(in_data_t)-1:0];
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW-$bits(out_item_t)){1'b0}}, out_q};

endmodule
`default_nettype wire

// ----- rtl/dsc_checker.sv -----
`default_nettype none
module dsc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tready_o,
  input logic                         m_axis_tvalid_o,
  input logic                         m_axis_tready_i,
  input logic [dsc_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import dsc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("Stalled result changed before its transfer.");

  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("Input stalled while the output side was free.");

  a_angles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[9:2] <= AngleMax && m_axis_tdata_o[17:10] <= AngleMax)
    else $error("Servo angle above its clamp.");

  a_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid_o)
    else $error("Result valid during reset.");

endmodule

bind twin_servo_door_controller dsc_checker u_dsc_checker (.*);
`default_nettype wire
